[rtl/core/ts_continuity_and_pcr_checker_top_defines.svh]
// Assertion helpers used by the checker's top level.
`ifndef TS_CONTINUITY_AND_PCR_CHECKER_TOP_DEFINES_SVH
`define TS_CONTINUITY_AND_PCR_CHECKER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/tcpc_pkg.sv]
package tcpc_pkg;

   localparam int unsigned PID_W   = 13;
   localparam int unsigned CC_W    = 4;
   localparam int unsigned PCR_W   = 42;
   localparam int unsigned TOTAL_W = 32;
   localparam int unsigned ENTRY_W = CC_W + 1;

   localparam int unsigned DEFAULT_PID_TABLE_DEPTH = 8192;
   localparam int unsigned QUEUE_DEPTH = 4;

   // Reciprocal shift for the pid-to-index reduction. With 13-bit pids the
   // truncated quotient is exact for every depth up to 8192.
   localparam int unsigned RECIP_SHIFT = 26;
   localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

   localparam logic [PCR_W-1:0] PCR_WRAP_PERIOD  = 42'd2576980377600;
   localparam logic [PCR_W-1:0] PCR_HALF_PERIOD  = 42'd1288490188800;
   localparam logic [PCR_W-1:0] PCR_THREE_HALVES = 42'd3865470566400;

   typedef enum logic [1:0] {
      PCR_NONE  = 2'd0,
      PCR_OK    = 2'd1,
      PCR_WRAP  = 2'd2,
      PCR_OTHER = 2'd3
   } pcr_status_type;

   typedef enum logic [1:0] {
      CC_OK   = 2'd0,
      CC_DUP  = 2'd1,
      CC_DISC = 2'd2
   } cc_status_type;

   // A classified packet header on its way from the front to the back.
   typedef struct packed {
      logic [PID_W-1:0] pid;
      logic             transport_error;
      logic             payload_present;
      logic [CC_W-1:0]  cc;
      pcr_status_type   pcr_status;
   } item_type;

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      return (v == {TOTAL_W{1'b1}}) ? v : v + TOTAL_W'(1);
   endfunction

endpackage

[rtl/core/tcpc_ifs.sv]
interface tcpc_req_if;
   logic                       valid;
   logic                       ready;
   logic [tcpc_pkg::PID_W-1:0] pid;
   logic                       transport_error;
   logic                       payload_present;
   logic [tcpc_pkg::CC_W-1:0]  cc_value;
   logic                       has_pcr;
   logic [tcpc_pkg::PCR_W-1:0] pcr_value;

   modport source (output valid, pid, transport_error, payload_present, cc_value,
                   has_pcr, pcr_value, input ready);
   modport sink (input valid, pid, transport_error, payload_present, cc_value,
                 has_pcr, pcr_value, output ready);
endinterface

interface tcpc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tcpc_pkg::PID_W-1:0]   result_pid;
   logic                         flag_error;
   logic [1:0]                   pcr_status;
   logic [1:0]                   cc_status;
   logic [tcpc_pkg::CC_W-1:0]    cc_expected;
   logic [tcpc_pkg::CC_W-1:0]    cc_found;
   logic [tcpc_pkg::TOTAL_W-1:0] packet_total;
   logic [tcpc_pkg::TOTAL_W-1:0] cc_error_total;
   logic [tcpc_pkg::TOTAL_W-1:0] flag_error_total;
   logic [tcpc_pkg::TOTAL_W-1:0] any_error_total;

   modport source (output valid, result_pid, flag_error, pcr_status, cc_status,
                   cc_expected, cc_found, packet_total, cc_error_total,
                   flag_error_total, any_error_total, input ready);
   modport sink (input valid, result_pid, flag_error, pcr_status, cc_status,
                 cc_expected, cc_found, packet_total, cc_error_total,
                 flag_error_total, any_error_total, output ready);
endinterface

[rtl/core/tcpc_front.sv]
module tcpc_front #(
   parameter int unsigned PID_TABLE_DEPTH = tcpc_pkg::DEFAULT_PID_TABLE_DEPTH,
   localparam int unsigned IDX_W = $clog2(PID_TABLE_DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   tcpc_req_if.sink           req_ch,
   input  logic               table_clearing,
   input  logic               q_full,
   output logic               q_push,
   output tcpc_pkg::item_type q_item,
   output logic [IDX_W-1:0]   q_idx
);

   localparam logic [tcpc_pkg::RECIP_W-1:0] RECIP =
      tcpc_pkg::RECIP_W'((64'd1 << tcpc_pkg::RECIP_SHIFT) / PID_TABLE_DEPTH + 1);
   localparam logic [tcpc_pkg::PID_W:0] DEPTH_C = (tcpc_pkg::PID_W + 1)'(PID_TABLE_DEPTH);
   localparam int unsigned PROD_W = tcpc_pkg::PID_W + tcpc_pkg::RECIP_W;

   logic                         accept;
   logic                         pcr_take;
   logic                         on_lock;
   logic [tcpc_pkg::PCR_W:0]     pcr_sub;

   logic                         s1_valid_ff, s1_valid_in;
   logic [tcpc_pkg::PID_W-1:0]   pid_ff;
   logic                         terr_ff;
   logic                         payload_ff;
   logic [tcpc_pkg::CC_W-1:0]    cc_ff;
   logic                         pcr_take_ff;
   logic                         on_lock_ff;
   logic                         older_ff;
   logic [tcpc_pkg::PCR_W-1:0]   diff_ff;
   logic [PROD_W-1:0]            prod_ff;

   logic                         locked_ff;
   logic [tcpc_pkg::PID_W-1:0]   lock_pid_ff;
   logic [tcpc_pkg::PCR_W-1:0]   last_pcr_ff;

   logic [tcpc_pkg::PID_W-1:0]   quot;
   logic [tcpc_pkg::PID_W-1:0]   quot_times_depth;
   logic                         wrap;

   assign q_push        = s1_valid_ff && !q_full;
   assign req_ch.ready  = !table_clearing && (!s1_valid_ff || q_push);
   assign accept        = req_ch.valid && req_ch.ready;
   assign pcr_take      = !req_ch.transport_error && req_ch.has_pcr;
   assign on_lock       = !locked_ff || (lock_pid_ff == req_ch.pid);
   assign pcr_sub       = {1'b0, last_pcr_ff} - {1'b0, req_ch.pcr_value};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         locked_ff   <= 1'b0;
         lock_pid_ff <= '0;
         last_pcr_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept && pcr_take) begin
            if (!locked_ff) begin
               locked_ff   <= 1'b1;
               lock_pid_ff <= req_ch.pid;
            end
            if (on_lock) begin
               last_pcr_ff <= req_ch.pcr_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pid_ff      <= req_ch.pid;
         terr_ff     <= req_ch.transport_error;
         payload_ff  <= req_ch.payload_present;
         cc_ff       <= req_ch.cc_value;
         pcr_take_ff <= pcr_take;
         on_lock_ff  <= on_lock;
         // No borrow means the new PCR is not above the old one.
         older_ff    <= !pcr_sub[tcpc_pkg::PCR_W];
         diff_ff     <= pcr_sub[tcpc_pkg::PCR_W-1:0];
         prod_ff     <= PROD_W'(req_ch.pid) * PROD_W'(RECIP);
      end
   end

   // The difference is below twice the period, so its remainder exceeds half
   // the period either between half and one period or above one and a half.
   assign wrap = older_ff &&
                 (((diff_ff > tcpc_pkg::PCR_HALF_PERIOD) && (diff_ff < tcpc_pkg::PCR_WRAP_PERIOD))
                  || (diff_ff > tcpc_pkg::PCR_THREE_HALVES));

   assign quot             = prod_ff[tcpc_pkg::RECIP_SHIFT +: tcpc_pkg::PID_W];
   assign quot_times_depth = tcpc_pkg::PID_W'(quot * DEPTH_C);
   assign q_idx            = IDX_W'(pid_ff - quot_times_depth);

   always_comb begin
      q_item.pid             = pid_ff;
      q_item.transport_error = terr_ff;
      q_item.payload_present = payload_ff;
      q_item.cc              = cc_ff;
      priority if (!pcr_take_ff) begin
         q_item.pcr_status = tcpc_pkg::PCR_NONE;
      end else if (!on_lock_ff) begin
         q_item.pcr_status = tcpc_pkg::PCR_OTHER;
      end else if (wrap) begin
         q_item.pcr_status = tcpc_pkg::PCR_WRAP;
      end else begin
         q_item.pcr_status = tcpc_pkg::PCR_OK;
      end
   end

endmodule

[rtl/core/tcpc_queue.sv]
module tcpc_queue #(
   parameter int unsigned DATA_W = 8,
   parameter int unsigned DEPTH  = tcpc_pkg::QUEUE_DEPTH,
   localparam int unsigned PTR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   logic [DATA_W-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W:0]    count_ff;

   assign full     = (count_ff == (PTR_W + 1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (PTR_W + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (PTR_W + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/tcpc_back.sv]
module tcpc_back #(
   parameter int unsigned PID_TABLE_DEPTH = tcpc_pkg::DEFAULT_PID_TABLE_DEPTH,
   localparam int unsigned IDX_W = $clog2(PID_TABLE_DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   output logic               q_pop,
   input  tcpc_pkg::item_type q_item,
   input  logic [IDX_W-1:0]   q_idx,
   tcpc_rsp_if.source         rsp_ch,
   output logic               table_clearing
);

   localparam int unsigned EW = tcpc_pkg::ENTRY_W;
   localparam int unsigned CW = tcpc_pkg::CC_W;
   localparam int unsigned TW = tcpc_pkg::TOTAL_W;

   // Each entry is a seen flag above the last counter value.
   logic [EW-1:0]      cc_mem [PID_TABLE_DEPTH];

   logic               clear_ff;
   logic [IDX_W-1:0]   clr_cnt_ff;

   logic               r_valid_ff;
   tcpc_pkg::item_type r_item_ff;
   logic [IDX_W-1:0]   r_idx_ff;
   logic [EW-1:0]      rd_ff;
   logic               fwd_hit_ff;
   logic [EW-1:0]      fwd_data_ff;

   logic               advance;
   logic [EW-1:0]      entry;
   logic               item_we;
   logic [EW-1:0]      item_wdata;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [EW-1:0]      mem_wdata;

   tcpc_pkg::cc_status_type cc_status;
   logic [CW-1:0]      expected;

   logic               rsp_valid_ff;
   logic [tcpc_pkg::PID_W-1:0] out_pid_ff;
   logic               out_terr_ff;
   tcpc_pkg::pcr_status_type out_pcr_ff;
   tcpc_pkg::cc_status_type  out_cc_status_ff;
   logic [CW-1:0]      out_expected_ff;
   logic [CW-1:0]      out_found_ff;

   logic [TW-1:0]      pkt_total_ff;
   logic [TW-1:0]      cc_err_total_ff;
   logic [TW-1:0]      flag_err_total_ff;
   logic [TW-1:0]      any_err_total_ff;

   assign table_clearing = clear_ff;
   assign advance        = r_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign q_pop          = !q_empty && !clear_ff && (!r_valid_ff || advance);

   // The read was issued at the edge that loaded this item; the write made at that
   // same edge is not in rd_ff and comes through the forwarding register instead.
   assign entry = fwd_hit_ff ? fwd_data_ff : rd_ff;

   always_comb begin
      cc_status = tcpc_pkg::CC_OK;
      expected  = r_item_ff.cc;
      if (r_item_ff.payload_present) begin
         if (entry[CW] && (entry[CW-1:0] == r_item_ff.cc)) begin
            cc_status = tcpc_pkg::CC_DUP;
         end else begin
            if (entry[CW]) begin
               expected = CW'(entry[CW-1:0] + CW'(1));
            end
            cc_status = (expected != r_item_ff.cc) ? tcpc_pkg::CC_DISC : tcpc_pkg::CC_OK;
         end
      end
   end

   assign item_we    = advance && r_item_ff.payload_present;
   assign item_wdata = {1'b1, r_item_ff.cc};
   assign mem_we     = clear_ff || item_we;
   assign mem_waddr  = clear_ff ? clr_cnt_ff : r_idx_ff;
   assign mem_wdata  = clear_ff ? '0 : item_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cc_mem[mem_waddr] <= mem_wdata;
      end
      if (q_pop) begin
         rd_ff <= cc_mem[q_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clear_ff) begin
         clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         if (clr_cnt_ff == IDX_W'(PID_TABLE_DEPTH - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (q_pop) begin
         r_valid_ff <= 1'b1;
      end else if (advance) begin
         r_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         r_item_ff   <= q_item;
         r_idx_ff    <= q_idx;
         fwd_hit_ff  <= item_we && (r_idx_ff == q_idx);
         fwd_data_ff <= item_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         pkt_total_ff      <= '0;
         cc_err_total_ff   <= '0;
         flag_err_total_ff <= '0;
         any_err_total_ff  <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            pkt_total_ff <= tcpc_pkg::sat_inc(pkt_total_ff);
            if (cc_status != tcpc_pkg::CC_OK) begin
               cc_err_total_ff <= tcpc_pkg::sat_inc(cc_err_total_ff);
            end
            if (r_item_ff.transport_error) begin
               flag_err_total_ff <= tcpc_pkg::sat_inc(flag_err_total_ff);
            end
            if ((cc_status != tcpc_pkg::CC_OK) || r_item_ff.transport_error) begin
               any_err_total_ff <= tcpc_pkg::sat_inc(any_err_total_ff);
            end
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_pid_ff       <= r_item_ff.pid;
         out_terr_ff      <= r_item_ff.transport_error;
         out_pcr_ff       <= r_item_ff.pcr_status;
         out_cc_status_ff <= cc_status;
         out_expected_ff  <= expected;
         out_found_ff     <= r_item_ff.cc;
      end
   end

   // The totals only move when a new item enters the output register, so
   // they always belong to the item shown.
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.result_pid       = out_pid_ff;
   assign rsp_ch.flag_error       = out_terr_ff;
   assign rsp_ch.pcr_status       = out_pcr_ff;
   assign rsp_ch.cc_status        = out_cc_status_ff;
   assign rsp_ch.cc_expected      = out_expected_ff;
   assign rsp_ch.cc_found         = out_found_ff;
   assign rsp_ch.packet_total     = pkt_total_ff;
   assign rsp_ch.cc_error_total   = cc_err_total_ff;
   assign rsp_ch.flag_error_total = flag_err_total_ff;
   assign rsp_ch.any_error_total  = any_err_total_ff;

endmodule

[rtl/core/ts_continuity_and_pcr_checker_top.sv]
// Transport stream continuity and PCR checker. It takes one parsed packet
// header per cycle while nothing downstream stalls and returns one result per
// header, in order, through the front, queue, table read and output registers.
// The rate is set by the per-PID counter table, a memory with one read and one
// write per cycle, where a write is forwarded to the next read of the same
// entry. After reset the table is cleared one entry per cycle, so req_ch.ready
// stays low until every entry is cleared. The first PID seen with a valid PCR
// is locked for PCR tracking until the next reset. A four-entry queue sits
// between header classification and the table check, and an output register
// lets a new header enter while a result waits to be taken.
`include "ts_continuity_and_pcr_checker_top_defines.svh"

module ts_continuity_and_pcr_checker_top #(
   parameter int unsigned PID_TABLE_DEPTH = tcpc_pkg::DEFAULT_PID_TABLE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   tcpc_req_if.sink   req_ch,
   tcpc_rsp_if.source rsp_ch
);

   localparam int unsigned IDX_W  = $clog2(PID_TABLE_DEPTH);
   localparam int unsigned ITEM_W = $bits(tcpc_pkg::item_type);
   localparam int unsigned Q_W    = ITEM_W + IDX_W;

   logic               table_clearing;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   tcpc_pkg::item_type front_item;
   logic [IDX_W-1:0]   front_idx;
   tcpc_pkg::item_type back_item;
   logic [IDX_W-1:0]   back_idx;
   logic [Q_W-1:0]     q_out;

   tcpc_front #(
      .PID_TABLE_DEPTH(PID_TABLE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .table_clearing (table_clearing),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (front_item),
      .q_idx          (front_idx)
   );

   tcpc_queue #(
      .DATA_W (Q_W),
      .DEPTH  (tcpc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({front_idx, front_item}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign back_item = tcpc_pkg::item_type'(q_out[ITEM_W-1:0]);
   assign back_idx  = q_out[Q_W-1:ITEM_W];

   tcpc_back #(
      .PID_TABLE_DEPTH(PID_TABLE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_item         (back_item),
      .q_idx          (back_idx),
      .rsp_ch         (rsp_ch),
      .table_clearing (table_clearing)
   );

   `TCPC_ASSERT_NEXT(a_clear_start, clock, 1'b0, reset, table_clearing, "no clear after reset")
   `TCPC_ASSERT_NOW(a_no_req_clr, clock, reset, table_clearing, !req_ch.ready, "accept in clear")
   `TCPC_ASSERT_NOW(a_no_rsp_clr, clock, reset, table_clearing, !rsp_ch.valid, "result in clear")

endmodule

[tb/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PID_W   = tcpc_pkg::PID_W;
   localparam int unsigned CC_W    = tcpc_pkg::CC_W;
   localparam int unsigned PCR_W   = tcpc_pkg::PCR_W;
   localparam int unsigned TOTAL_W = tcpc_pkg::TOTAL_W;

   localparam int unsigned TABLE_DEPTH  = tcpc_pkg::DEFAULT_PID_TABLE_DEPTH;
   localparam int unsigned RANDOM_ITEMS = 530;
   localparam int unsigned QUIET_TAIL   = 60;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam logic [63:0] WRAP_PERIOD  = 64'(tcpc_pkg::PCR_WRAP_PERIOD);
   localparam logic [PID_W-1:0] PCR_PID = 13'd100;

   typedef struct {
      logic [PID_W-1:0] pid;
      logic             terr;
      logic             payload;
      logic [CC_W-1:0]  cc;
      logic             has_pcr;
      logic [PCR_W-1:0] pcr;
      bit               drain_first;
   } header_type;

   typedef struct {
      logic [PID_W-1:0]         pid;
      logic                     flag_error;
      tcpc_pkg::pcr_status_type pcr_status;
      tcpc_pkg::cc_status_type  cc_status;
      logic [CC_W-1:0]          cc_expected;
      logic [CC_W-1:0]          cc_found;
      logic [TOTAL_W-1:0]       packet_total;
      logic [TOTAL_W-1:0]       cc_error_total;
      logic [TOTAL_W-1:0]       flag_error_total;
      logic [TOTAL_W-1:0]       any_error_total;
   } report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcpc_req_if req_ch ();
   tcpc_rsp_if rsp_ch ();

   ts_continuity_and_pcr_checker_top #(
      .PID_TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #2 clock = ~clock;

   // Shadow state of the checker.
   bit                 cc_seen [TABLE_DEPTH];
   logic [CC_W-1:0]    cc_last [TABLE_DEPTH];
   bit                 pcr_locked;
   logic [PID_W-1:0]   pcr_pid;
   logic [PCR_W-1:0]   last_pcr;
   logic [TOTAL_W-1:0] packet_count;
   logic [TOTAL_W-1:0] cc_error_count;
   logic [TOTAL_W-1:0] flag_error_count;
   logic [TOTAL_W-1:0] any_error_count;

   header_type header_queue[$];
   report_type expected_reports[$];
   header_type in_flight;

   int  gap_left;
   int  stall_left;
   bit  tail_quiet;
   int  fail_count;
   int  cycle_count;
   int  reports_seen;
   int  dup_seen;
   int  disc_seen;
   int  wrap_seen;
   int  other_seen;

   function automatic logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] v);
      return (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic report_type classify_packet(header_type h);
      report_type  r;
      int unsigned idx;
      logic [63:0] old_pcr;
      logic [63:0] new_pcr;
      r.pid         = h.pid;
      r.flag_error  = h.terr;
      r.pcr_status  = tcpc_pkg::PCR_NONE;
      r.cc_status   = tcpc_pkg::CC_OK;
      r.cc_expected = h.cc;
      r.cc_found    = h.cc;

      // An errored packet's PCR is not trusted and neither locks nor updates.
      if (!h.terr && h.has_pcr) begin
         if (!pcr_locked) begin
            pcr_locked = 1'b1;
            pcr_pid    = h.pid;
         end
         if (pcr_pid == h.pid) begin
            old_pcr  = 64'(last_pcr);
            new_pcr  = 64'(h.pcr);
            last_pcr = h.pcr;
            if (new_pcr < old_pcr && ((old_pcr - new_pcr) % WRAP_PERIOD) > WRAP_PERIOD / 2)
               r.pcr_status = tcpc_pkg::PCR_WRAP;
            else
               r.pcr_status = tcpc_pkg::PCR_OK;
         end else begin
            r.pcr_status = tcpc_pkg::PCR_OTHER;
         end
      end

      if (h.payload) begin
         idx = int'(h.pid) % TABLE_DEPTH;
         if (cc_seen[idx] && cc_last[idx] == h.cc) begin
            r.cc_status = tcpc_pkg::CC_DUP;
         end else begin
            if (cc_seen[idx])
               r.cc_expected = cc_last[idx] + 1'b1;
            cc_seen[idx] = 1'b1;
            cc_last[idx] = h.cc;
            if (r.cc_expected != h.cc)
               r.cc_status = tcpc_pkg::CC_DISC;
         end
      end

      if (r.cc_status != tcpc_pkg::CC_OK)
         cc_error_count = bump(cc_error_count);
      if (h.terr)
         flag_error_count = bump(flag_error_count);
      if (r.cc_status != tcpc_pkg::CC_OK || h.terr)
         any_error_count = bump(any_error_count);
      packet_count = bump(packet_count);

      r.packet_total     = packet_count;
      r.cc_error_total   = cc_error_count;
      r.flag_error_total = flag_error_count;
      r.any_error_total  = any_error_count;
      return r;
   endfunction

   function automatic logic [PCR_W-1:0] random_pcr();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[PCR_W-1:0];
   endfunction

   function automatic void add_header(logic [PID_W-1:0] pid, logic terr, logic payload,
                                      logic [CC_W-1:0] cc, logic has_pcr,
                                      logic [PCR_W-1:0] pcr, bit drain_first);
      header_type h;
      h.pid         = pid;
      h.terr        = terr;
      h.payload     = payload;
      h.cc          = cc;
      h.has_pcr     = has_pcr;
      h.pcr         = pcr;
      h.drain_first = drain_first;
      header_queue.push_back(h);
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Header driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid           <= 1'b0;
         req_ch.pid             <= '0;
         req_ch.transport_error <= 1'b0;
         req_ch.payload_present <= 1'b0;
         req_ch.cc_value        <= '0;
         req_ch.has_pcr         <= 1'b0;
         req_ch.pcr_value       <= '0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_reports.push_back(classify_packet(in_flight));
         tail_quiet <= (header_queue.size() <= QUIET_TAIL);
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (header_queue.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (header_queue[0].drain_first && expected_reports.size() != 0) begin
               // Hold off until every outstanding report is back.
               req_ch.valid <= 1'b0;
            end else if (header_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
               gap_left = int'($urandom_range(0, 9));
               req_ch.valid <= 1'b0;
            end else begin
               in_flight = header_queue.pop_front();
               req_ch.pid             <= in_flight.pid;
               req_ch.transport_error <= in_flight.terr;
               req_ch.payload_present <= in_flight.payload;
               req_ch.cc_value        <= in_flight.cc;
               req_ch.has_pcr         <= in_flight.has_pcr;
               req_ch.pcr_value       <= in_flight.pcr;
               req_ch.valid           <= 1'b1;
            end
         end
      end
   end

   // Report monitor and receiver stalls.
   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_reports.size() == 0) begin
               $error("report for pid %0h arrived with none outstanding", rsp_ch.result_pid);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               reports_seen++;
               if (want.cc_status == tcpc_pkg::CC_DUP)
                  dup_seen++;
               if (want.cc_status == tcpc_pkg::CC_DISC)
                  disc_seen++;
               if (want.pcr_status == tcpc_pkg::PCR_WRAP)
                  wrap_seen++;
               if (want.pcr_status == tcpc_pkg::PCR_OTHER)
                  other_seen++;
               check_field("result_pid", 64'(want.pid), 64'(rsp_ch.result_pid));
               check_field("flag_error", 64'(want.flag_error), 64'(rsp_ch.flag_error));
               check_field("pcr_status", 64'(want.pcr_status), 64'(rsp_ch.pcr_status));
               check_field("cc_status", 64'(want.cc_status), 64'(rsp_ch.cc_status));
               check_field("cc_expected", 64'(want.cc_expected), 64'(rsp_ch.cc_expected));
               check_field("cc_found", 64'(want.cc_found), 64'(rsp_ch.cc_found));
               check_field("packet_total", 64'(want.packet_total),
                           64'(rsp_ch.packet_total));
               check_field("cc_error_total", 64'(want.cc_error_total),
                           64'(rsp_ch.cc_error_total));
               check_field("flag_error_total", 64'(want.flag_error_total),
                           64'(rsp_ch.flag_error_total));
               check_field("any_error_total", 64'(want.any_error_total),
                           64'(rsp_ch.any_error_total));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
            stall_left = int'($urandom_range(0, 9));
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      header_type       h;
      logic [PID_W-1:0] stream_pid [6];
      logic [CC_W-1:0]  next_cc [6];
      logic [63:0]      pcr_now;
      logic [63:0]      step;
      int               k;
      int               pick;

      pcr_locked       = 1'b0;
      pcr_pid          = '0;
      last_pcr         = '0;
      packet_count     = '0;
      cc_error_count   = '0;
      flag_error_count = '0;
      any_error_count  = '0;
      fail_count       = 0;
      foreach (cc_seen[i]) begin
         cc_seen[i] = 1'b0;
         cc_last[i] = '0;
      end

      // Continuity: first sighting, duplicate, step, discontinuity, counter wrap.
      add_header(13'd0, 1'b0, 1'b1, 4'd0, 1'b0, '0, 1'b0);
      add_header(13'd0, 1'b0, 1'b1, 4'd0, 1'b0, '0, 1'b0);
      add_header(13'd0, 1'b0, 1'b1, 4'd1, 1'b0, '0, 1'b0);
      add_header(13'd0, 1'b0, 1'b1, 4'd5, 1'b0, '0, 1'b0);
      add_header(13'h1FFF, 1'b0, 1'b1, 4'd15, 1'b0, '0, 1'b0);
      add_header(13'h1FFF, 1'b0, 1'b1, 4'd0, 1'b0, '0, 1'b0);
      add_header(13'h1FFF, 1'b0, 1'b0, 4'd9, 1'b0, '0, 1'b0);
      // An errored PCR must not lock; the next clean one does.
      add_header(PCR_PID, 1'b1, 1'b1, 4'd3, 1'b1, 42'd1000, 1'b0);
      add_header(PCR_PID, 1'b0, 1'b1, 4'd4, 1'b1, 42'd1000, 1'b0);
      add_header(13'd200, 1'b0, 1'b1, 4'd7, 1'b1, 42'd5, 1'b1);
      add_header(PCR_PID, 1'b0, 1'b1, 4'd5, 1'b1, 42'd2000, 1'b0);
      add_header(PCR_PID, 1'b0, 1'b0, 4'd5, 1'b1, 42'd500, 1'b0);
      add_header(PCR_PID, 1'b0, 1'b1, 4'd6, 1'b1, tcpc_pkg::PCR_WRAP_PERIOD - 1'b1, 1'b0);
      add_header(PCR_PID, 1'b0, 1'b1, 4'd7, 1'b1, 42'd10, 1'b0);
      add_header(PCR_PID, 1'b0, 1'b1, 4'd8, 1'b1, 42'h3FF_FFFF_FFFF, 1'b0);
      add_header(PCR_PID, 1'b0, 1'b1, 4'd9, 1'b1, 42'd1, 1'b0);
      add_header(PCR_PID, 1'b0, 1'b1, 4'd10, 1'b1, 42'd0, 1'b0);
      add_header(13'h1FFF, 1'b1, 1'b1, 4'd0, 1'b1, 42'h3FF_FFFF_FFFF, 1'b0);
      add_header(13'h0AAA, 1'b0, 1'b1, 4'hA, 1'b1, 42'h2AA_AAAA_AAAA, 1'b0);
      add_header(13'h1555, 1'b1, 1'b0, 4'h5, 1'b0, 42'h155_5555_5555, 1'b0);
      add_header(PCR_PID, 1'b0, 1'b1, 4'hF, 1'b1, 42'h155_5555_5555, 1'b0);

      // Random part: mostly a handful of well-behaved streams with the odd
      // duplicate or skip, plus a share of completely random headers.
      stream_pid[0] = PCR_PID;
      for (int i = 1; i < 5; i++)
         stream_pid[i] = PID_W'($urandom_range(0, 8191));
      stream_pid[5] = 13'h1FFF;
      foreach (next_cc[i])
         next_cc[i] = CC_W'($urandom_range(0, 15));
      pcr_now = 64'(42'h155_5555_5555);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         h.drain_first = (i == RANDOM_ITEMS / 2);
         h.pcr = random_pcr();
         if ($urandom_range(0, 99) < 80) begin
            k = int'($urandom_range(0, 5));
            h.pid     = stream_pid[k];
            h.payload = ($urandom_range(0, 9) != 0);
            h.terr    = ($urandom_range(0, 29) == 0);
            pick = int'($urandom_range(0, 19));
            if (pick == 0)
               h.cc = next_cc[k] - 1'b1;
            else if (pick == 1)
               h.cc = next_cc[k] + CC_W'($urandom_range(1, 14));
            else
               h.cc = next_cc[k];
            if (h.payload && pick != 0)
               next_cc[k] = h.cc + 1'b1;
            h.has_pcr = (k == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 11) == 0);
            if (k == 0 && h.has_pcr) begin
               // Large steps sometimes land behind the last value and wrap.
               if ($urandom_range(0, 5) == 0)
                  step = {$urandom, $urandom} % WRAP_PERIOD;
               else
                  step = 64'($urandom_range(1, 2000000));
               pcr_now = (pcr_now + step) % WRAP_PERIOD;
               h.pcr = pcr_now[PCR_W-1:0];
            end
         end else begin
            h.pid     = PID_W'($urandom_range(0, 8191));
            h.terr    = 1'($urandom_range(0, 1));
            h.payload = 1'($urandom_range(0, 1));
            h.cc      = CC_W'($urandom_range(0, 15));
            h.has_pcr = 1'($urandom_range(0, 1));
         end
         header_queue.push_back(h);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (!(header_queue.size() == 0 && !req_ch.valid && expected_reports.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_reports.size() != 0) begin
         $error("%0d reports never arrived", expected_reports.size());
         fail_count++;
      end

      $display("Checked %0d packet reports: %0d duplicates, %0d discontinuities,",
               reports_seen, dup_seen, disc_seen);
      $display("%0d PCR wraps and %0d PCRs on other PIDs, locked PID %0d.",
               wrap_seen, other_seen, pcr_pid);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tcpc_pkg.sv
rtl/core/tcpc_ifs.sv
rtl/core/tcpc_front.sv
rtl/core/tcpc_queue.sv
rtl/core/tcpc_back.sv
rtl/core/ts_continuity_and_pcr_checker_top.sv
tb/testbench.sv
